// ===== design/pusu_pkg.sv =====
`timescale 1ns / 1ps
// shared types, register indexes and helpers for the particle update step unit
// no dependencies

package pusu_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_GRAVITY  = 3'd0;
   localparam logic [2:0] REG_WIND     = 3'd1;
   localparam logic [2:0] REG_DRAG_EN  = 3'd2;
   localparam logic [2:0] REG_LIFE     = 3'd3;
   localparam logic [2:0] REG_FADE     = 3'd4;
   localparam logic [2:0] REG_NORMAL   = 3'd5;
   localparam logic [2:0] REG_POINT    = 3'd6;
   localparam logic [2:0] REG_RESPONSE = 3'd7;

   // collision responses
   localparam logic [1:0] MODE_NONE    = 2'd0;
   localparam logic [1:0] MODE_BOUNCE  = 2'd1;
   localparam logic [1:0] MODE_RECYCLE = 2'd2;
   localparam logic [1:0] MODE_STICK   = 2'd3;

   // plane distance threshold, 0.001 in Q.16
   localparam logic signed [34:0] PLANE_THRESH = 35'sd65;

   localparam int QUOT_W = 8;
   localparam int NUM_W  = 24;
   localparam int DEN_W  = 16;

   typedef enum logic [1:0] {
      ALPHA_ZERO,
      ALPHA_FULL,
      ALPHA_DIV
   } alpha_sel_type;

   // particle data that rides alongside the arithmetic
   typedef struct packed {
      logic [2:0][15:0] p0;
      logic [2:0][15:0] v0;
      logic [15:0]      age;
      logic [15:0]      dt;
      logic             expired;
      alpha_sel_type    asel;
   } side_type;

   // clamp to signed 16 bits
   function automatic logic signed [15:0] sat16(input logic signed [39:0] x);
      logic signed [15:0] r;
      if (x > 40'sd32767) begin
         r = 16'sh7fff;
      end else if (x < -40'sd32768) begin
         r = -16'sh8000;
      end else begin
         r = x[15:0];
      end
      return r;
   endfunction

endpackage

// ===== design/pusu_div.sv =====
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage, 8-bit quotient
// depends on pusu_pkg for widths; caller guarantees num < den * 256

module pusu_div (
   input  logic                       clock,
   input  logic                       enable,
   input  logic [pusu_pkg::NUM_W-1:0] num,
   input  logic [pusu_pkg::DEN_W-1:0] den,
   output logic [pusu_pkg::QUOT_W-1:0] quot
);

   localparam int QW = pusu_pkg::QUOT_W;
   localparam int DW = pusu_pkg::DEN_W;

   logic [DW-1:0] rem_ff [QW];
   logic [QW-1:0] low_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [QW-1:0] quo_ff [QW];

   for (genvar j = 0; j < QW; j++) begin : g_step
      logic [DW-1:0] rem_prev;
      logic [QW-1:0] low_prev;
      logic [DW-1:0] den_prev;
      logic [QW-1:0] quo_prev;
      logic [DW:0]   trial;
      logic          ge;
      logic [DW-1:0] rem_in;

      // stage inputs: raw operands for the first step
      if (j == 0) begin : g_first
         assign rem_prev = num[pusu_pkg::NUM_W-1:QW];
         assign low_prev = num[QW-1:0];
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign low_prev = low_ff[j-1];
         assign den_prev = den_ff[j-1];
         assign quo_prev = quo_ff[j-1];
      end

      // shift in one numerator bit and try the subtraction
      always_comb begin
         trial  = {rem_prev, low_prev[QW-1]};
         ge     = trial >= {1'b0, den_prev};
         rem_in = ge ? DW'(trial - {1'b0, den_prev}) : trial[DW-1:0];
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[j] <= rem_in;
            low_ff[j] <= {low_prev[QW-2:0], 1'b0};
            den_ff[j] <= den_prev;
            quo_ff[j] <= {quo_prev[QW-2:0], ge};
         end
      end
   end

   assign quot = quo_ff[QW-1];

endmodule

// ===== design/particle_update_step_unit.sv =====
`timescale 1ns / 1ps
// particle update step unit: one Euler step with a plane collision test
// req beats cross the stages and output register; one particle per cycle sustained
// the whole pipeline advances together and stalls only while a rsp beat waits
// reset (synchronous) clears the valid bits and loads the register defaults
// depends on pusu_pkg and pusu_div

module particle_update_step_unit (
   input  logic         clock,
   input  logic         reset,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, age, time_step (16 bits each)
   input  logic [127:0] req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z (16 each),
   // alpha (9), new_age (16), zero fill (7)
   output logic [127:0] rsp_tdata,
   // expired
   output logic         rsp_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_addr,
   input  logic [47:0]  csr_wdata
);

   localparam int NSTG = 10;

   // configuration registers
   logic [47:0] gravity_ff, wind_ff, normal_ff, point_ff;
   logic        drag_en_ff;
   logic [15:0] life_ff;
   logic [31:0] fade_ff;
   logic [10:0] response_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff  <= '0;
         wind_ff     <= '0;
         drag_en_ff  <= 1'b1;
         life_ff     <= 16'd256;
         fade_ff     <= 32'h0100_0100;
         normal_ff   <= '0;
         point_ff    <= '0;
         response_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_addr)
            pusu_pkg::REG_GRAVITY:  gravity_ff  <= csr_wdata;
            pusu_pkg::REG_WIND:     wind_ff     <= csr_wdata;
            pusu_pkg::REG_DRAG_EN:  drag_en_ff  <= csr_wdata[0];
            pusu_pkg::REG_LIFE:     life_ff     <= csr_wdata[15:0];
            pusu_pkg::REG_FADE:     fade_ff     <= csr_wdata[31:0];
            pusu_pkg::REG_NORMAL:   normal_ff   <= csr_wdata;
            pusu_pkg::REG_POINT:    point_ff    <= csr_wdata;
            pusu_pkg::REG_RESPONSE: response_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   // pipeline advance: moves unless the output beat is stuck
   logic adv;
   logic out_valid_ff;
   logic valid_ff [NSTG];

   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NSTG; k++) valid_ff[k] <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= req_tvalid;
         for (int k = 1; k < NSTG; k++) valid_ff[k] <= valid_ff[k-1];
         out_valid_ff <= valid_ff[NSTG-1];
      end
   end

   // input unpacking and side data
   pusu_pkg::side_type side_in;
   pusu_pkg::side_type side_ff [NSTG];
   logic [15:0] life_left;
   logic [15:0] fin, fout;
   logic [pusu_pkg::NUM_W-1:0] div_num;
   logic [pusu_pkg::DEN_W-1:0] div_den;
   logic signed [16:0] dt_s;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         side_in.p0[i] = req_tdata[16*i +: 16];
         side_in.v0[i] = req_tdata[48 + 16*i +: 16];
      end
      side_in.age     = req_tdata[111:96];
      side_in.dt      = req_tdata[127:112];
      side_in.expired = side_in.age >= life_ff;
      fin       = fade_ff[15:0];
      fout      = fade_ff[31:16];
      life_left = life_ff - side_in.age;
      dt_s      = $signed({1'b0, side_in.dt});
      // alpha source and divider operands
      if (side_in.expired) begin
         side_in.asel = pusu_pkg::ALPHA_ZERO;
         div_num      = {side_in.age, 8'd0};
         div_den      = fin;
      end else if (side_in.age < fin) begin
         side_in.asel = pusu_pkg::ALPHA_DIV;
         div_num      = {side_in.age, 8'd0};
         div_den      = fin;
      end else if (life_left < fout) begin
         side_in.asel = pusu_pkg::ALPHA_DIV;
         div_num      = {life_left, 8'd0};
         div_den      = fout;
      end else begin
         side_in.asel = pusu_pkg::ALPHA_FULL;
         div_num      = {side_in.age, 8'd0};
         div_den      = fin;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < NSTG; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   // fade divider, quotient lines up with stage 8
   logic [pusu_pkg::QUOT_W-1:0] quot;

   pusu_div u_div (
      .clock  (clock),
      .enable (adv),
      .num    (div_num),
      .den    (div_den),
      .quot   (quot)
   );

   // stage 0: gravity products
   logic signed [32:0] gprod_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++)
            gprod_ff[i] <= $signed(gravity_ff[16*i +: 16]) * dt_s;
      end
   end

   // stage 1: velocity plus gravity
   logic signed [15:0] v1_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++)
            v1_ff[i] <= pusu_pkg::sat16(40'($signed(side_ff[0].v0[i]))
                        + 40'((gprod_ff[i] + 33'sd128) >>> 8));
      end
   end

   // stage 2: drag products
   logic signed [33:0] dprod_ff [3];
   logic signed [15:0] v2c_ff   [3];
   logic signed [16:0] dt1_s;
   assign dt1_s = $signed({1'b0, side_ff[1].dt});
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            dprod_ff[i] <= (17'($signed(wind_ff[16*i +: 16])) - 17'(v1_ff[i])) * dt1_s;
            v2c_ff[i]   <= v1_ff[i];
         end
      end
   end

   // stage 3: velocity after drag
   logic signed [15:0] v3_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++)
            v3_ff[i] <= drag_en_ff
               ? pusu_pkg::sat16(40'(v2c_ff[i]) + 40'((dprod_ff[i] + 34'sd128) >>> 8))
               : v2c_ff[i];
      end
   end

   // stage 4: displacement products
   logic signed [32:0] pprod_ff [3];
   logic signed [15:0] v4_ff    [3];
   logic signed [16:0] dt3_s;
   assign dt3_s = $signed({1'b0, side_ff[3].dt});
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            pprod_ff[i] <= v3_ff[i] * dt3_s;
            v4_ff[i]    <= v3_ff[i];
         end
      end
   end

   // stage 5: new position
   logic signed [15:0] p5_ff [3];
   logic signed [15:0] v5_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            p5_ff[i] <= pusu_pkg::sat16(40'($signed(side_ff[4].p0[i]))
                        + 40'((pprod_ff[i] + 33'sd128) >>> 8));
            v5_ff[i] <= v4_ff[i];
         end
      end
   end

   // stage 6: plane distance and normal velocity terms
   logic signed [32:0] dterm_ff  [3];
   logic signed [31:0] nvterm_ff [3];
   logic signed [15:0] p6_ff [3];
   logic signed [15:0] v6_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            dterm_ff[i]  <= (17'($signed(point_ff[16*i +: 16])) - 17'(p5_ff[i]))
                            * $signed(normal_ff[16*i +: 16]);
            nvterm_ff[i] <= $signed(normal_ff[16*i +: 16]) * v5_ff[i];
            p6_ff[i]     <= p5_ff[i];
            v6_ff[i]     <= v5_ff[i];
         end
      end
   end

   // stage 7: dot product sums
   logic signed [34:0] d_ff;
   logic signed [33:0] nv_ff;
   logic signed [15:0] p7_ff [3];
   logic signed [15:0] v7_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff  <= 35'(dterm_ff[0]) + 35'(dterm_ff[1]) + 35'(dterm_ff[2]);
         nv_ff <= 34'(nvterm_ff[0]) + 34'(nvterm_ff[1]) + 34'(nvterm_ff[2]);
         for (int i = 0; i < 3; i++) begin
            p7_ff[i] <= p6_ff[i];
            v7_ff[i] <= v6_ff[i];
         end
      end
   end

   // stage 8: normal velocity projected back, alpha settled
   logic signed [49:0] nvn_ff [3];
   logic               behind8_ff;
   logic [8:0]         alpha8_ff;
   logic signed [15:0] p8_ff [3];
   logic signed [15:0] v8_ff [3];
   logic [8:0]         alpha_in;

   always_comb begin
      unique case (side_ff[7].asel)
         pusu_pkg::ALPHA_DIV:  alpha_in = {1'b0, quot};
         pusu_pkg::ALPHA_FULL: alpha_in = 9'd256;
         default:              alpha_in = 9'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         behind8_ff <= d_ff > pusu_pkg::PLANE_THRESH;
         alpha8_ff  <= alpha_in;
         for (int i = 0; i < 3; i++) begin
            nvn_ff[i] <= nv_ff * $signed(normal_ff[16*i +: 16]);
            p8_ff[i]  <= p7_ff[i];
            v8_ff[i]  <= v7_ff[i];
         end
      end
   end

   // stage 9: scale by one plus restitution
   logic signed [60:0] t_ff [3];
   logic               behind9_ff;
   logic [8:0]         alpha9_ff;
   logic signed [15:0] p9_ff [3];
   logic signed [15:0] v9_ff [3];
   logic signed [10:0] kr_s;
   assign kr_s = $signed({1'b0, 10'd256 + {1'b0, response_ff[10:2]}});
   always_ff @(posedge clock) begin
      if (adv) begin
         behind9_ff <= behind8_ff;
         alpha9_ff  <= alpha8_ff;
         for (int i = 0; i < 3; i++) begin
            t_ff[i]  <= nvn_ff[i] * kr_s;
            p9_ff[i] <= p8_ff[i];
            v9_ff[i] <= v8_ff[i];
         end
      end
   end

   // output stage: collision response and expiry selection
   logic signed [15:0] pos_in [3];
   logic signed [15:0] vel_in [3];
   logic [15:0]        age_in;
   logic [16:0]        age_sum;
   logic [1:0]         mode;
   logic               act;
   logic signed [36:0] tr;
   pusu_pkg::side_type sd;

   always_comb begin
      sd      = side_ff[NSTG-1];
      mode    = response_ff[1:0];
      act     = behind9_ff && !sd.expired;
      age_sum = {1'b0, sd.age} + {1'b0, life_ff};
      age_in  = sd.age;
      tr      = '0;
      if (act && mode == pusu_pkg::MODE_RECYCLE)
         age_in = age_sum[16] ? 16'hffff : age_sum[15:0];
      for (int i = 0; i < 3; i++) begin
         tr        = 37'((t_ff[i] + 61'sd8388608) >>> 24);
         pos_in[i] = p9_ff[i];
         vel_in[i] = v9_ff[i];
         if (sd.expired) begin
            pos_in[i] = $signed(sd.p0[i]);
            vel_in[i] = $signed(sd.v0[i]);
         end else if (act) begin
            case (mode)
               pusu_pkg::MODE_BOUNCE: begin
                  pos_in[i] = $signed(sd.p0[i]);
                  vel_in[i] = pusu_pkg::sat16(40'(v9_ff[i]) - 40'(tr));
               end
               pusu_pkg::MODE_STICK: begin
                  pos_in[i] = $signed(sd.p0[i]);
                  vel_in[i] = '0;
               end
               default: ;
            endcase
         end
      end
   end

   logic [127:0] rsp_data_ff;
   logic         rsp_exp_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            rsp_data_ff[16*i +: 16]      <= pos_in[i];
            rsp_data_ff[48 + 16*i +: 16] <= vel_in[i];
         end
         rsp_data_ff[104:96]  <= alpha9_ff;
         rsp_data_ff[120:105] <= age_in;
         rsp_data_ff[127:121] <= '0;
         rsp_exp_ff           <= sd.expired;
      end
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_exp_ff;
   assign rsp_tvalid = out_valid_ff;

endmodule

// ===== test/particle_update_step_unit_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the particle update step unit
// drives particle beats and register writes, predicts each result and compares it
// depends on pusu_pkg and the particle_update_step_unit rtl

module particle_update_step_unit_tb;

   typedef struct {
      logic [15:0] px, py, pz, vx, vy, vz, age, dt;
   } particle_type;

   typedef struct {
      logic [127:0] data;
      logic         expired;
   } step_out_type;

   logic         clock;
   logic         reset;
   logic [127:0] req_tdata;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic         csr_valid;
   logic         csr_ready;
   logic [2:0]   csr_addr;
   logic [47:0]  csr_wdata;

   // shadow copy of the registers
   logic [47:0] gravity_q, wind_q, normal_q, point_q;
   logic        drag_q;
   logic [15:0] life_q;
   logic [31:0] fade_q;
   logic [10:0] response_q;

   particle_type pending_particles[$];
   step_out_type expected_steps[$];
   int        mismatches = 0;
   int        results_seen = 0;
   int        hold_count = 0;
   bit        hold_start = 0;
   bit        hold_done = 0;
   bit        no_idle = 0;
   bit        req_pause = 0;

   particle_update_step_unit dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic longint comp16(logic [47:0] v, int i);
      return longint'($signed(v[16*i +: 16]));
   endfunction

   function automatic longint clamp16(longint x);
      if (x > 32767) return 32767;
      if (x < -32768) return -32768;
      return x;
   endfunction

   // round half up then floor shift
   function automatic longint round_shift(longint x, int n);
      return (x + (longint'(1) << (n - 1))) >>> n;
   endfunction

   // one Euler step with the plane test
   function automatic step_out_type euler_step(particle_type it);
      step_out_type r;
      longint p0[3], p[3], v[3], nrm[3];
      longint age, dt, life, fin, fout, alpha, new_age, d, nv, t, kr;
      logic   exp_flag;
      logic [15:0] raw[3];
      age = it.age; dt = it.dt; life = life_q;
      fin = fade_q[15:0]; fout = fade_q[31:16];
      new_age = age; d = 0; exp_flag = 0;
      raw[0] = it.px; raw[1] = it.py; raw[2] = it.pz;
      for (int i = 0; i < 3; i++) begin
         p0[i] = longint'($signed(raw[i]));
         p[i] = p0[i];
      end
      v[0] = longint'($signed(it.vx));
      v[1] = longint'($signed(it.vy));
      v[2] = longint'($signed(it.vz));
      if (age >= life) begin
         exp_flag = 1;
         alpha = 0;
      end else begin
         for (int i = 0; i < 3; i++) begin
            v[i] = clamp16(v[i] + round_shift(comp16(gravity_q, i) * dt, 8));
            if (drag_q)
               v[i] = clamp16(v[i] + round_shift((comp16(wind_q, i) - v[i]) * dt, 8));
         end
         if (age < fin) alpha = (age * 256) / fin;
         else if (life - age < fout) alpha = ((life - age) * 256) / fout;
         else alpha = 256;
         for (int i = 0; i < 3; i++) begin
            p[i] = clamp16(p0[i] + round_shift(v[i] * dt, 8));
            nrm[i] = comp16(normal_q, i);
            d += (comp16(point_q, i) - p[i]) * nrm[i];
         end
         if (d > 65) begin
            kr = response_q[10:2];
            case (response_q[1:0])
               pusu_pkg::MODE_BOUNCE: begin
                  nv = 0;
                  for (int i = 0; i < 3; i++) nv += nrm[i] * v[i];
                  for (int i = 0; i < 3; i++) begin
                     t = round_shift(nv * nrm[i] * (256 + kr), 24);
                     p[i] = p0[i];
                     v[i] = clamp16(v[i] - t);
                  end
               end
               pusu_pkg::MODE_RECYCLE: begin
                  new_age = age + life;
                  if (new_age > 65535) new_age = 65535;
               end
               pusu_pkg::MODE_STICK: begin
                  for (int i = 0; i < 3; i++) begin
                     p[i] = p0[i];
                     v[i] = 0;
                  end
               end
               default: ;
            endcase
         end
      end
      r.data = {7'd0, new_age[15:0], alpha[8:0], v[2][15:0], v[1][15:0], v[0][15:0],
                p[2][15:0], p[1][15:0], p[0][15:0]};
      r.expired = exp_flag;
      return r;
   endfunction

   function automatic logic [127:0] pack_particle(particle_type it);
      return {it.dt, it.age, it.vz, it.vy, it.vx, it.pz, it.py, it.px};
   endfunction

   // sender: pops queued particles, predicts on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         req_tdata <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_steps.push_back(euler_step(pending_particles.pop_front()));
         end
         if (req_tvalid && !(req_tready)) begin
            // hold the offered beat
         end else if (!req_pause && pending_particles.size() > 0 &&
                      (no_idle || $urandom_range(99) >= 28)) begin
            req_tvalid <= 1;
            req_tdata <= pack_particle(pending_particles[0]);
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // receiver with random idling and a long hold-off window
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_start && !hold_done) begin
         hold_done <= 1;
         hold_count <= 200;
         rsp_tready <= 0;
      end else if (hold_count > 0) begin
         hold_count <= hold_count - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(99) >= 28);
      end
   end

   // result checker
   always @(posedge clock) begin
      step_out_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen <= results_seen + 1;
         if (expected_steps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected rsp beat %h", rsp_tdata);
         end else begin
            e = expected_steps.pop_front();
            if (e.data !== rsp_tdata || e.expired !== rsp_tuser) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("rsp beat differs: expected %h/%b got %h/%b",
                           e.data, e.expired, rsp_tdata, rsp_tuser);
            end
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [47:0] val);
      csr_valid <= 1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      case (idx)
         pusu_pkg::REG_GRAVITY:  gravity_q = val;
         pusu_pkg::REG_WIND:     wind_q = val;
         pusu_pkg::REG_DRAG_EN:  drag_q = val[0];
         pusu_pkg::REG_LIFE:     life_q = val[15:0];
         pusu_pkg::REG_FADE:     fade_q = val[31:0];
         pusu_pkg::REG_NORMAL:   normal_q = val;
         pusu_pkg::REG_POINT:    point_q = val;
         default:                response_q = val[10:0];
      endcase
   endtask

   task automatic drain_all();
      while (pending_particles.size() != 0 || req_tvalid || expected_steps.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 1) ? 16'h7fff : 16'h8000);
         default: return 16'($signed($urandom_range(0, 2048)) - 1024);
      endcase
   endfunction

   function automatic particle_type rand_particle();
      particle_type it;
      it.px = rand_coord(); it.py = rand_coord(); it.pz = rand_coord();
      it.vx = rand_coord(); it.vy = rand_coord(); it.vz = rand_coord();
      it.age = ($urandom_range(3) == 0) ? 16'($urandom) :
               16'($urandom_range(0, int'(life_q) + 8));
      it.dt = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
      return it;
   endfunction

   function automatic logic [47:0] rand_vec(int span);
      logic [47:0] v;
      for (int i = 0; i < 3; i++) v[16*i +: 16] = 16'($urandom_range(0, 2*span) - span);
      return v;
   endfunction

   task automatic random_config();
      write_reg(pusu_pkg::REG_GRAVITY,
                $urandom_range(3) == 0 ? 48'({$urandom, $urandom}) : rand_vec(512));
      write_reg(pusu_pkg::REG_WIND,
                $urandom_range(3) == 0 ? 48'({$urandom, $urandom}) : rand_vec(512));
      write_reg(pusu_pkg::REG_DRAG_EN, 48'($urandom_range(1)));
      write_reg(pusu_pkg::REG_LIFE, 48'($urandom_range(1, 3) == 1 ? $urandom_range(1, 65535)
                                                              : $urandom_range(1, 2048)));
      write_reg(pusu_pkg::REG_FADE,
                {16'd0, 16'($urandom_range(0, 600)), 16'($urandom_range(0, 600))});
      write_reg(pusu_pkg::REG_NORMAL,
                $urandom_range(2) == 0 ? 48'({$urandom, $urandom}) : rand_vec(256));
      write_reg(pusu_pkg::REG_POINT, rand_vec(1024));
      write_reg(pusu_pkg::REG_RESPONSE, 48'($urandom_range(0, 2047)));
   endtask

   // stimulus
   initial begin
      particle_type it;
      reset = 1;
      csr_valid = 0; csr_addr = pusu_pkg::REG_GRAVITY; csr_wdata = '0;
      gravity_q = 0; wind_q = 0; drag_q = 1; life_q = 256; fade_q = 32'h01000100;
      normal_q = 0; point_q = 0; response_q = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: defaults, expiry edge, zero and extreme fields
      it = '{16'h7fff, 16'h8000, 16'd0, 16'h7fff, 16'h8000, 16'h0100, 16'd255, 16'hffff};
      pending_particles.push_back(it);
      it.age = 16'd256; pending_particles.push_back(it);
      it.age = 16'hffff; pending_particles.push_back(it);
      it = '{default: 16'd0}; pending_particles.push_back(it);
      it = '{16'h0100, 16'h0100, 16'h0100, 16'h8000, 16'h8000, 16'h8000, 16'd100, 16'h0200};
      pending_particles.push_back(it);
      drain_all();

      // plane through origin, normal +y, each response mode
      write_reg(pusu_pkg::REG_GRAVITY, {16'd0, 16'hf600, 16'd0});
      write_reg(pusu_pkg::REG_NORMAL, {16'd0, 16'h0100, 16'd0});
      write_reg(pusu_pkg::REG_POINT, 48'd0);
      write_reg(pusu_pkg::REG_FADE, 48'd0);
      write_reg(pusu_pkg::REG_LIFE, 48'h00_0000_ffff);
      for (int m = 0; m < 4; m++) begin
         write_reg(pusu_pkg::REG_RESPONSE, {37'd0, 9'(m * 170), 2'(m)});
         it = '{16'h0010, 16'h0008, 16'h0000, 16'h0040, 16'hff00, 16'h0000, 16'hfff0, 16'h0080};
         pending_particles.push_back(it);
         it.py = 16'h0800; pending_particles.push_back(it);
         it.age = 16'h0000; it.py = 16'h0001; pending_particles.push_back(it);
         drain_all();
      end
      write_reg(pusu_pkg::REG_DRAG_EN, 48'd0);
      write_reg(pusu_pkg::REG_WIND, 48'h7fff_8000_7fff);
      write_reg(pusu_pkg::REG_FADE, 48'h0000_ffff_ffff);
      it = '{16'h1000, 16'h1000, 16'h1000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'hffff};
      pending_particles.push_back(it);
      drain_all();

      // random phases with fresh settings
      for (int ph = 0; ph < 12; ph++) begin
         random_config();
         no_idle = (ph == 3);
         for (int k = 0; k < 100; k++) pending_particles.push_back(rand_particle());
         if (ph == 5) begin
            hold_start = 1;
         end
         if (ph == 7) begin
            while (pending_particles.size() > 50) @(posedge clock);
            req_pause = 1;
            while (req_tvalid || expected_steps.size() != 0) @(posedge clock);
            req_pause = 0;
         end
         drain_all();
      end

      $display("covered %0d particle beats across twelve register settings,", results_seen);
      $display("all response modes, expiry, fade edges, stalls and a full back-pressure");
      if (mismatches == 0) begin
         $display("particle_update_step_unit: match");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("particle_update_step_unit: mismatch");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("particle_update_step_unit: mismatch");
      $finish;
   end

endmodule
